>>> design/mmts_pkg.sv
package mmts_pkg;

  // Operation carried in the input side-band field.
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Status codes reported with each result word.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // Control sequencer states.
  typedef enum logic {
    S_IDLE     = 1'b0,
    S_POP_WAIT = 1'b1
  } state_t;

  // Fixed widths of the result fields.
  localparam int unsigned OUT_VAL_W   = 32;
  localparam int unsigned DEPTH_W     = 5;
  localparam int unsigned OUT_TDATA_W = 104;

endpackage

>>> design/min_max_tracking_stack_core.sv
// A push or an underflowing pop has its result word registered in the cycle after acceptance;
// a pop that removes an entry first waits in S_POP_WAIT for the RAM read.
// Throughput: one push per cycle while the output is free or draining; a pop that removes an
// entry blocks input in S_POP_WAIT, set by the registered stack RAM read of the entry below the old top.
// Reset: synchronous, active low; clears the fill count, the sequencer and the output
// valid. Stack RAM contents are not cleared; only entries below the fill count are used.
module min_max_tracking_stack_core
  import mmts_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [31:0]            in_tdata,   // [31:0] push_value
  input  logic                   in_tuser,   // [0] kind
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [1:0] status, [6:2] depth, [7] is_empty, [39:8] top_value,
  // [71:40] lowest_value, [103:72] highest_value
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int unsigned ADDR_W  = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ENTRY_W = 3 * VALUE_WIDTH;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic signed [VALUE_WIDTH-1:0] top_val_r, top_val_nxt;
  logic signed [VALUE_WIDTH-1:0] top_lo_r, top_lo_nxt;
  logic signed [VALUE_WIDTH-1:0] top_hi_r, top_hi_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic                   ram_wr_en;
  logic [ADDR_W-1:0]      ram_wr_addr;
  logic [ENTRY_W-1:0]     ram_wr_data;
  logic [ADDR_W-1:0]      ram_rd_addr;
  logic [ENTRY_W-1:0]     ram_rd_data;

  logic                   in_fire;
  logic                   load_out;
  status_t                status;
  logic signed [63:0]     push_ext;
  logic signed [VALUE_WIDTH-1:0] push_v;
  logic signed [VALUE_WIDTH-1:0] new_lo, new_hi;
  logic [31:0]            fill_wide;
  logic signed [63:0]     top_ext, lo_ext, hi_ext;
  logic                   res_empty;

  // One entry holds value, running minimum and running maximum.
  mmts_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Input is taken when idle and the output register is free or draining.
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;

  // Convert the pushed word to the stored width.
  assign push_ext = 64'($signed(in_tdata));
  assign push_v   = VALUE_WIDTH'(push_ext);
  assign new_lo   = (fill_r == '0 || push_v < top_lo_r) ? push_v : top_lo_r;
  assign new_hi   = (fill_r == '0 || push_v > top_hi_r) ? push_v : top_hi_r;

  // Sequencer, stack update and RAM control.
  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    top_val_nxt = top_val_r;
    top_lo_nxt  = top_lo_r;
    top_hi_nxt  = top_hi_r;
    ram_wr_en   = 1'b0;
    ram_wr_addr = ADDR_W'(fill_r);
    ram_wr_data = {new_hi, new_lo, push_v};
    ram_rd_addr = ADDR_W'(fill_r - CNT_W'(2));
    load_out    = 1'b0;
    status      = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_tuser == KIND_PUSH) begin
            load_out = 1'b1;
            if (fill_r == CNT_W'(STACK_DEPTH)) begin
              status = ST_OVERFLOW;
            end else begin
              ram_wr_en   = 1'b1;
              fill_nxt    = fill_r + CNT_W'(1);
              top_val_nxt = push_v;
              top_lo_nxt  = new_lo;
              top_hi_nxt  = new_hi;
            end
          end else if (fill_r == '0) begin
            load_out = 1'b1;
            status   = ST_UNDERFLOW;
          end else begin
            // Fetch the entry that becomes the new top.
            fill_nxt  = fill_r - CNT_W'(1);
            state_nxt = S_POP_WAIT;
          end
        end
      end
      S_POP_WAIT: begin
        top_val_nxt = ram_rd_data[VALUE_WIDTH-1:0];
        top_lo_nxt  = ram_rd_data[2*VALUE_WIDTH-1:VALUE_WIDTH];
        top_hi_nxt  = ram_rd_data[3*VALUE_WIDTH-1:2*VALUE_WIDTH];
        load_out    = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Assemble the result word from the state after the operation.
  always_comb begin
    fill_wide = 32'(fill_nxt);
    res_empty = (fill_nxt == '0);
    top_ext   = 64'(top_val_nxt);
    lo_ext    = 64'(top_lo_nxt);
    hi_ext    = 64'(top_hi_nxt);
    if (res_empty) begin
      top_ext = '0;
      lo_ext  = '0;
      hi_ext  = '0;
    end
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {hi_ext[OUT_VAL_W-1:0], lo_ext[OUT_VAL_W-1:0],
                       top_ext[OUT_VAL_W-1:0], res_empty,
                       fill_wide[DEPTH_W-1:0], status};
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    top_val_r  <= top_val_nxt;
    top_lo_r   <= top_lo_nxt;
    top_hi_r   <= top_hi_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> design/mmts_ram.sv
module mmts_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> dv/tb_min_max_tracking_stack_core.sv
`timescale 1ns / 100ps

module tb_min_max_tracking_stack_core;
  import mmts_pkg::*;

  localparam int unsigned LEVELS = 16;
  localparam int unsigned RANDOM_OPS = 1500;

  // One queued stack operation; drain_first holds it back until all results are in.
  typedef struct {
    logic        kind;
    logic [31:0] value;
    bit          drain_first;
  } stack_op_t;

  // Stack state visible after one operation.
  typedef struct {
    status_t     status;
    logic [4:0]  depth;
    logic        is_empty;
    logic [31:0] top_value;
    logic [31:0] lowest_value;
    logic [31:0] highest_value;
  } stack_view_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [31:0]            in_tdata = '0;   // [31:0] push_value
  logic                   in_tuser = 1'b0; // [0] kind
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [1:0] status, [6:2] depth, [7] is_empty, [39:8] top_value,
  // [71:40] lowest_value, [103:72] highest_value
  logic [OUT_TDATA_W-1:0] out_tdata;

  stack_op_t   pending_ops[$];
  stack_view_t expected_views[$];
  int          mismatch_count = 0;
  int          accepted_ops = 0;
  int          total_ops = 0;

  // Shadow copy of the stack with the running minimum and maximum per level.
  logic signed [31:0] shadow_values[LEVELS];
  logic signed [31:0] shadow_lows[LEVELS];
  logic signed [31:0] shadow_highs[LEVELS];
  int unsigned        shadow_fill = 0;

  // Burst and stall control.
  int burst_left = 1;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_timer = 0;

  min_max_tracking_stack_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Apply one push or pop to the shadow stack and return the resulting view.
  function automatic stack_view_t apply_stack_op(logic kind, logic [31:0] value);
    stack_view_t        view;
    logic signed [31:0] v;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    view.status = ST_OK;
    v = value;
    if (kind == KIND_PUSH) begin
      if (shadow_fill >= LEVELS) begin
        view.status = ST_OVERFLOW;
      end else begin
        lo = v;
        hi = v;
        if (shadow_fill != 0) begin
          lo = shadow_lows[shadow_fill - 1];
          hi = shadow_highs[shadow_fill - 1];
          if (v < lo) lo = v;
          if (v > hi) hi = v;
        end
        shadow_values[shadow_fill] = v;
        shadow_lows[shadow_fill] = lo;
        shadow_highs[shadow_fill] = hi;
        shadow_fill++;
      end
    end else begin
      if (shadow_fill == 0) view.status = ST_UNDERFLOW;
      else shadow_fill--;
    end
    view.depth = shadow_fill[4:0];
    if (shadow_fill == 0) begin
      view.is_empty = 1'b1;
      view.top_value = '0;
      view.lowest_value = '0;
      view.highest_value = '0;
    end else begin
      view.is_empty = 1'b0;
      view.top_value = shadow_values[shadow_fill - 1];
      view.lowest_value = shadow_lows[shadow_fill - 1];
      view.highest_value = shadow_highs[shadow_fill - 1];
    end
    return view;
  endfunction

  // Push values favor the extremes, small numbers and repeats to exercise ties.
  function automatic logic [31:0] pick_push_value(logic [31:0] last_value);
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'h7FFF_FFFF;
      1: v = 32'h8000_0000;
      2: v = 32'($signed($urandom_range(0, 16)) - 8);
      3: v = last_value;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  function automatic stack_op_t make_op(logic kind, logic [31:0] value, bit drain_first);
    stack_op_t op;
    op.kind = kind;
    op.value = value;
    op.drain_first = drain_first;
    return op;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Driver: sends queued words in bursts and runs the shadow stack on each accepted word.
  always @(posedge clk) begin : drive_inputs
    stack_op_t op;
    bit        accepted;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      accepted = in_tvalid && in_tready;
      if (accepted) begin
        expected_views.push_back(apply_stack_op(in_tuser, in_tdata));
        accepted_ops++;
      end
      if (!in_tvalid || accepted) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_ops.size() > 0 &&
                     (!pending_ops[0].drain_first || expected_views.size() == 0)) begin
          op = pending_ops.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= op.value;
          in_tuser <= op.kind;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result word with the oldest expected view.
  always @(posedge clk) begin : check_results
    stack_view_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_views.size() == 0) begin
        $error("result word with no expected view: %0h", out_tdata);
        mismatch_count++;
      end else begin
        want = expected_views.pop_front();
        check_field("status", 32'(want.status), 32'(out_tdata[1:0]));
        check_field("depth", 32'(want.depth), 32'(out_tdata[6:2]));
        check_field("is_empty", 32'(want.is_empty), 32'(out_tdata[7]));
        check_field("top_value", want.top_value, out_tdata[39:8]);
        check_field("lowest_value", want.lowest_value, out_tdata[71:40]);
        check_field("highest_value", want.highest_value, out_tdata[103:72]);
      end
    end

    // The receiver switches between stall patterns every so often.
    if (stall_timer == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_timer = $urandom_range(32, 160);
    end else begin
      stall_timer--;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= (stall_timer % 5 != 0);
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Stimulus: directed corner cases, then random fill and drain segments.
  initial begin : run_stimulus
    logic [31:0] last_value;
    int          seg_mode;
    int          seg_len;
    int          push_pct;
    int          segment;
    int          random_count;
    bit          drain_next;

    // Pop on an empty stack, then the value extremes.
    pending_ops.push_back(make_op(KIND_POP, $urandom(), 1'b0));
    pending_ops.push_back(make_op(KIND_PUSH, 32'h7FFF_FFFF, 1'b0));
    pending_ops.push_back(make_op(KIND_PUSH, 32'h8000_0000, 1'b0));
    pending_ops.push_back(make_op(KIND_PUSH, 32'hFFFF_FFFF, 1'b0));
    pending_ops.push_back(make_op(KIND_PUSH, 32'h0000_0000, 1'b0));
    pending_ops.push_back(make_op(KIND_PUSH, 32'h0000_0001, 1'b0));
    // Fill to the top, then push onto the full stack.
    for (int i = 5; i < LEVELS; i++) begin
      pending_ops.push_back(make_op(KIND_PUSH, $urandom(), 1'b0));
    end
    pending_ops.push_back(make_op(KIND_PUSH, 32'h1234_5678, 1'b0));
    // Pop five entries off the full stack; the first pop waits for the pipeline to empty.
    pending_ops.push_back(make_op(KIND_POP, $urandom(), 1'b1));
    for (int i = 0; i < 4; i++) begin
      pending_ops.push_back(make_op(KIND_POP, $urandom(), 1'b0));
    end

    // Random segments lean toward filling or draining so both ends are reached often.
    last_value = '0;
    random_count = 0;
    segment = 0;
    while (random_count < RANDOM_OPS) begin
      seg_mode = $urandom_range(0, 2);
      seg_len = $urandom_range(5, 40);
      push_pct = (seg_mode == 0) ? 85 : (seg_mode == 1) ? 15 : 50;
      drain_next = (segment % 8 == 7);
      for (int i = 0; i < seg_len; i++) begin
        if ($urandom_range(0, 99) < push_pct) begin
          last_value = pick_push_value(last_value);
          pending_ops.push_back(make_op(KIND_PUSH, last_value, drain_next));
        end else begin
          pending_ops.push_back(make_op(KIND_POP, $urandom(), drain_next));
        end
        drain_next = 1'b0;
        random_count++;
      end
      segment++;
    end
    total_ops = pending_ops.size();

    // Wait for every word to be accepted and every result to arrive.
    @(posedge clk);
    while (accepted_ops < total_ops || expected_views.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_views.size() > 0) begin
      $error("%0d expected views left without a result", expected_views.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
